@@ hw/rtl/rcc_pkg.sv @@
// Shared types and constants for the rainflow cycle counter.
// Used by rcc_ctrl, rcc_dp and rainflow_cycle_counter_timed; no dependencies.
package rcc_pkg;

  // default sizes
  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;

  // cycle kind codes on the result side
  localparam logic [1:0] KIND_HALF = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic load_item;   // request accepted: push point or flag overflow
    logic pop_half;    // count half cycle at stack bottom
    logic pop_full;    // count full cycle, drop two inner points
    logic refill;      // reload cached entries from memory read
    logic flush_rd;    // read residue pair
    logic flush_step;  // emit residue pair if nonzero, advance
    logic end_emit;    // emit end marker, empty stack
    logic send_last;   // move held result out as last of run
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic pop_cond;    // three or more points and older range <= newer range
    logic older_nz;    // older range nonzero
    logic cnt_is3;     // exactly three points on stack
    logic last;        // current request is last of sequence
    logic flush_more;  // residue pairs left to read
    logic pair_diff;   // residue pair values differ
    logic pend_valid;  // a result is held back
    logic out_free;    // output register can take a result
  } status_t;

endpackage

@@ hw/rtl/rcc_ctrl.sv @@
// Controller state machine of the rainflow cycle counter.
// Depends on rcc_pkg (cmd_t, status_t); drives rcc_dp through commands.
module rcc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  rcc_pkg::status_t st,
  output rcc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    REFILL,
    FL_RD,
    FL_EMIT,
    FL_END,
    FINISH
  } state_t;

  state_t state, state_next;
  logic   emit_ok;

  // a new result may enter the hold register if the held one can leave
  assign emit_ok  = !st.pend_valid || st.out_free;
  assign s_tready = (state == IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = CHECK;
        end
      end
      CHECK: begin
        if (st.pop_cond) begin
          if (!st.older_nz || emit_ok) begin
            if (st.cnt_is3) begin
              cmd.pop_half = 1'b1;
            end else begin
              cmd.pop_full = 1'b1;
              state_next   = REFILL;
            end
          end
        end else if (st.last) begin
          state_next = FL_RD;
        end else begin
          state_next = FINISH;
        end
      end
      REFILL: begin
        cmd.refill = 1'b1;
        state_next = CHECK;
      end
      FL_RD: begin
        if (st.flush_more) begin
          cmd.flush_rd = 1'b1;
          state_next   = FL_EMIT;
        end else begin
          state_next = FL_END;
        end
      end
      FL_EMIT: begin
        if (!st.pair_diff || emit_ok) begin
          cmd.flush_step = 1'b1;
          state_next     = FL_RD;
        end
      end
      FL_END: begin
        if (emit_ok) begin
          cmd.end_emit = 1'b1;
          state_next   = FINISH;
        end
      end
      FINISH: begin
        if (!st.pend_valid) begin
          state_next = IDLE;
        end else if (st.out_free) begin
          cmd.send_last = 1'b1;
          state_next    = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_item, cmd.pop_half, cmd.pop_full, cmd.refill,
              cmd.flush_rd, cmd.flush_step, cmd.end_emit, cmd.send_last}))
    else $error("rcc_ctrl: more than one command");

endmodule

@@ hw/rtl/rcc_dp.sv @@
// Datapath of the rainflow cycle counter: point stack memory, top-of-stack
// cache, range compare, result hold and output registers. Depends on rcc_pkg.
module rcc_dp #(
  parameter int DEPTH = rcc_pkg::STACK_DEPTH_DEF,
  parameter int VW    = rcc_pkg::VALUE_WIDTH_DEF,
  parameter int TW    = rcc_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rcc_pkg::cmd_t        cmd,
  output rcc_pkg::status_t     st,
  input  logic signed [VW-1:0] in_value,
  input  logic [TW-1:0]        in_time,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VW-1:0]        out_amp,
  output logic signed [VW:0]   out_sum,
  output logic [1:0]           out_kind,
  output logic [TW-1:0]        out_start,
  output logic [TW:0]          out_period,
  output logic                 out_ovf,
  output logic                 out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // physical slot of stack position k, stack bottom at base
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [CW-1:0] k);
    logic [AW:0] s;
    s = (AW+1)'(b) + (AW+1)'(k);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [VW:0] abs_diff(input logic signed [VW-1:0] a,
                                           input logic signed [VW-1:0] b);
    logic signed [VW:0] d;
    d = (VW+1)'(a) - (VW+1)'(b);
    return (d < 0) ? (VW+1)'(-d) : (VW+1)'(d);
  endfunction

  // stack memory
  logic signed [VW-1:0] mem_val  [DEPTH];
  logic [TW-1:0]        mem_time [DEPTH];
  logic signed [VW-1:0] rd_a_val, rd_b_val;
  logic [TW-1:0]        rd_a_time, rd_b_time;

  // top three entries, c0 is the top
  logic signed [VW-1:0] c0_val, c1_val, c2_val;
  logic [TW-1:0]        c0_time, c1_time, c2_time;

  logic [CW-1:0] cnt;
  logic [AW-1:0] base;
  logic [CW-1:0] fidx;
  logic          last_q;
  logic          ovf;

  // held result
  logic                 pend_valid;
  logic [VW-1:0]        pend_amp;
  logic signed [VW:0]   pend_sum;
  logic [1:0]           pend_kind;
  logic [TW-1:0]        pend_start;
  logic [TW:0]          pend_period;
  logic                 pend_ovf;

  logic          full;
  logic [VW:0]   older, newer;
  logic          out_free;
  logic          emit_new;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
  logic signed [VW-1:0] wr_val;
  logic [TW-1:0] wr_time;
  logic          rd_en;

  // result fields
  logic signed [VW-1:0] p0, p1;
  logic [TW-1:0]        t0, t1, dt;
  logic [1:0]           new_kind;
  logic [VW:0]          new_abs;

  // range compare and status
  assign full     = (cnt == CW'(DEPTH));
  assign older    = abs_diff(c1_val, c2_val);
  assign newer    = abs_diff(c0_val, c1_val);
  assign out_free = !out_valid || out_ready;

  assign st.pop_cond   = (cnt >= CW'(3)) && (older <= newer);
  assign st.older_nz   = (older != '0);
  assign st.cnt_is3    = (cnt == CW'(3));
  assign st.last       = last_q;
  assign st.flush_more = ((fidx + CW'(1)) < cnt);
  assign st.pair_diff  = (rd_a_val != rd_b_val);
  assign st.pend_valid = pend_valid;
  assign st.out_free   = out_free;

  // memory port selection
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = slot(base, cnt);
    wr_val    = in_value;
    wr_time   = in_time;
    rd_en     = cmd.pop_full || cmd.flush_rd;
    rd_a_addr = slot(base, fidx);
    rd_b_addr = slot(base, CW'(fidx + CW'(1)));
    if (cmd.load_item && !full) begin
      wr_en = 1'b1;
    end else if (cmd.pop_full) begin
      // top point moves down over the two removed points
      wr_en   = 1'b1;
      wr_addr = slot(base, CW'(cnt - CW'(3)));
      wr_val  = c0_val;
      wr_time = c0_time;
    end
    if (cmd.pop_full) begin
      rd_a_addr = slot(base, CW'(cnt - CW'(4)));
      rd_b_addr = (cnt >= CW'(5)) ? slot(base, CW'(cnt - CW'(5))) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_val[wr_addr]  <= wr_val;
      mem_time[wr_addr] <= wr_time;
    end
    if (rd_en) begin
      rd_a_val  <= mem_val[rd_a_addr];
      rd_a_time <= mem_time[rd_a_addr];
      rd_b_val  <= mem_val[rd_b_addr];
      rd_b_time <= mem_time[rd_b_addr];
    end
  end

  // new result: counted cycle, residue pair or end marker
  always_comb begin
    p0       = c2_val;
    p1       = c1_val;
    t0       = c2_time;
    t1       = c1_time;
    new_kind = cmd.pop_full ? rcc_pkg::KIND_FULL : rcc_pkg::KIND_HALF;
    if (cmd.flush_step) begin
      p0 = rd_a_val;
      p1 = rd_b_val;
      t0 = rd_a_time;
      t1 = rd_b_time;
    end else if (cmd.end_emit) begin
      p0       = '0;
      p1       = '0;
      t0       = '0;
      t1       = '0;
      new_kind = rcc_pkg::KIND_END;
    end
    dt       = t1 - t0;
    new_abs  = abs_diff(p1, p0);
    emit_new = ((cmd.pop_half || cmd.pop_full) && st.older_nz) ||
               (cmd.flush_step && st.pair_diff) || cmd.end_emit;
  end

  // stack control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      base <= '0;
      fidx <= '0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        fidx <= '0;
        if (full) begin
          ovf <= 1'b1;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
      if (cmd.pop_half) begin
        cnt  <= CW'(2);
        base <= (base == AW'(DEPTH - 1)) ? '0 : base + AW'(1);
      end
      if (cmd.pop_full) begin
        cnt <= cnt - CW'(2);
      end
      if (cmd.flush_step) begin
        fidx <= fidx + CW'(1);
      end
      if (cmd.end_emit) begin
        cnt <= '0;
      end
    end
  end

  // top-of-stack cache
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      last_q <= in_last;
      if (!full) begin
        c0_val  <= in_value;
        c0_time <= in_time;
        c1_val  <= c0_val;
        c1_time <= c0_time;
        c2_val  <= c1_val;
        c2_time <= c1_time;
      end
    end
    if (cmd.refill) begin
      c1_val  <= rd_a_val;
      c1_time <= rd_a_time;
      c2_val  <= rd_b_val;
      c2_time <= rd_b_time;
    end
  end

  // hold one result back until it is known whether another follows
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (emit_new) begin
      pend_valid <= 1'b1;
    end else if (cmd.send_last) begin
      pend_valid <= 1'b0;
    end
    if (emit_new) begin
      pend_amp    <= new_abs[VW-1:0];
      pend_sum    <= (VW+1)'(p0) + (VW+1)'(p1);
      pend_kind   <= new_kind;
      pend_start  <= t0;
      pend_period <= {dt, 1'b0};
      pend_ovf    <= ovf;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((emit_new && pend_valid) || cmd.send_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if ((emit_new && pend_valid) || cmd.send_last) begin
      out_amp    <= pend_amp;
      out_sum    <= pend_sum;
      out_kind   <= pend_kind;
      out_start  <= pend_start;
      out_period <= pend_period;
      out_ovf    <= pend_ovf;
      out_last   <= cmd.send_last;
    end
  end

  // held result only leaves into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((emit_new && pend_valid) || cmd.send_last) |-> out_free)
    else $error("rcc_dp: result overwritten in output register");

  // overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf)
    else $error("rcc_dp: overflow flag cleared");

  // end marker empties the stack
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.end_emit |=> (cnt == '0))
    else $error("rcc_dp: stack not empty after end marker");

endmodule

@@ hw/rtl/rainflow_cycle_counter_timed.sv @@
// Top level of the rainflow cycle counter with cycle timing.
// Depends on rcc_pkg, rcc_ctrl and rcc_dp.
//
// Usage: each input request carries one turning point (value, time stamp)
// and tlast marks the final point of a sequence. Each output request is one
// counted cycle: doubled amplitude, doubled mean, start time, doubled period,
// the sticky overflow flag, and the cycle kind on tuser (half, full or end
// marker). m_tlast marks the final result caused by one input request.
// Steps: a point is taken in IDLE, the range compare runs in CHECK, a half
// cycle is counted in CHECK and a full cycle in CHECK then REFILL (memory
// reread of the stack below the top). A last point adds FL_RD and FL_EMIT
// per residue pair, then FL_RD for the final residue check and FL_END for
// the end marker. REFILL is needed because of the single stack memory with
// two registered read ports.
// Results are held one deep so the final one can carry m_tlast; a stalled
// m_tready stalls the counter while earlier results wait, and a new point is
// taken while the last result still sits in the output register.
// Reset (rst, synchronous) empties the stack and clears the overflow flag;
// stack memory contents are not cleared and need no clearing pass.
module rainflow_cycle_counter_timed #(
  parameter int STACK_DEPTH = rcc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rcc_pkg::VALUE_WIDTH_DEF,
  parameter int TIME_WIDTH  = rcc_pkg::TIME_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // tdata: turning_value, turning_time
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((VALUE_WIDTH + TIME_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic s_tlast,
  // tdata: double_amplitude, mean_sum, start_time, period, stack_overflow
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((2 * VALUE_WIDTH + 2 * TIME_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_tdata,
  // tuser: cycle_kind
  output logic [1:0] m_tuser,
  output logic m_tlast
);

  localparam int OUT_W = ((2 * VALUE_WIDTH + 2 * TIME_WIDTH + 3 + 7) / 8) * 8;

  rcc_pkg::cmd_t    cmd;
  rcc_pkg::status_t st;

  logic signed [VALUE_WIDTH-1:0] in_value;
  logic [TIME_WIDTH-1:0]         in_time;
  logic [VALUE_WIDTH-1:0]        out_amp;
  logic signed [VALUE_WIDTH:0]   out_sum;
  logic [TIME_WIDTH-1:0]         out_start;
  logic [TIME_WIDTH:0]           out_period;
  logic                          out_ovf;

  // unpack request fields
  assign in_value = s_tdata[VALUE_WIDTH-1:0];
  assign in_time  = s_tdata[VALUE_WIDTH + TIME_WIDTH - 1:VALUE_WIDTH];

  rcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rcc_dp #(
    .DEPTH (STACK_DEPTH),
    .VW    (VALUE_WIDTH),
    .TW    (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_value   (in_value),
    .in_time    (in_time),
    .in_last    (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_amp    (out_amp),
    .out_sum    (out_sum),
    .out_kind   (m_tuser),
    .out_start  (out_start),
    .out_period (out_period),
    .out_ovf    (out_ovf),
    .out_last   (m_tlast)
  );

  // pack result fields, lowest field first, zero filled to whole bytes
  assign m_tdata = OUT_W'({out_ovf, out_period, out_start, out_sum, out_amp});

endmodule

@@ dv/rainflow_cycle_checker.sv @@
// Scoreboard for the rainflow cycle counter: watches both stream channels,
// predicts the counted cycles of each accepted point and compares them.
// Depends on rcc_pkg for the default sizes and the cycle kind codes.
module rainflow_cycle_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // tdata: turning_value, turning_time
  input  logic [47:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // tdata: double_amplitude, mean_sum, start_time, period, stack_overflow
  input  logic [103:0] m_tdata,
  // tuser: cycle_kind
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);

  localparam int DEPTH = rcc_pkg::STACK_DEPTH_DEF;
  localparam int VW    = rcc_pkg::VALUE_WIDTH_DEF;
  localparam int TW    = rcc_pkg::TIME_WIDTH_DEF;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [VW-1:0]        dbl_amp;
    logic signed [VW:0]   mean2;
    logic [1:0]           kind;
    logic [TW-1:0]        t_start;
    logic [TW:0]          period;
    logic                 ovf;
    logic                 last;
  } cycle_t;

  cycle_t        expected_cycles[$];
  int            point_vals[DEPTH];
  logic [TW-1:0] point_times[DEPTH];
  int            stack_fill;
  logic          overflow_seen;
  int            mismatches;

  function automatic int mag(int x);
    return (x < 0) ? -x : x;
  endfunction

  task automatic add_cycle(int p0, int p1, logic [TW-1:0] t0, logic [TW-1:0] t1,
                           logic [1:0] kind);
    cycle_t        c;
    logic [TW-1:0] dt;
    dt        = t1 - t0;
    c.dbl_amp = VW'(mag(p1 - p0));
    c.mean2   = (VW+1)'(p0 + p1);
    c.kind    = kind;
    c.t_start = t0;
    c.period  = {dt, 1'b0};
    c.ovf     = overflow_seen;
    c.last    = 1'b0;
    expected_cycles.push_back(c);
  endtask

  // push one turning point, count cycles, flush the residue on the last one
  task automatic predict_point(logic [VW-1:0] raw_val, logic [TW-1:0] t, logic lst);
    int            j;
    int            older;
    int            newer;
    int            p0;
    int            p1;
    logic [TW-1:0] t0;
    logic [TW-1:0] t1;
    int            queued_before;
    cycle_t        tail;
    queued_before = expected_cycles.size();
    if (stack_fill < DEPTH) begin
      point_vals[stack_fill]  = $signed(raw_val);
      point_times[stack_fill] = t;
      stack_fill++;
      while (stack_fill >= 3) begin
        j     = stack_fill - 1;
        older = mag(point_vals[j-1] - point_vals[j-2]);
        newer = mag(point_vals[j] - point_vals[j-1]);
        if (older > newer) break;
        p0 = point_vals[j-2];
        p1 = point_vals[j-1];
        t0 = point_times[j-2];
        t1 = point_times[j-1];
        if (j == 2) begin
          // half cycle: oldest point leaves the bottom
          point_vals[0]  = point_vals[1];
          point_vals[1]  = point_vals[2];
          point_times[0] = point_times[1];
          point_times[1] = point_times[2];
          stack_fill     = 2;
          if (older > 0) add_cycle(p0, p1, t0, t1, rcc_pkg::KIND_HALF);
        end else begin
          // full cycle: the two inner points go away
          point_vals[j-2]  = point_vals[j];
          point_times[j-2] = point_times[j];
          stack_fill       = j - 1;
          if (older > 0) add_cycle(p0, p1, t0, t1, rcc_pkg::KIND_FULL);
        end
      end
    end else begin
      overflow_seen = 1'b1;
    end

    if (lst) begin
      for (int i = 0; i + 1 < stack_fill; i++) begin
        if (point_vals[i] != point_vals[i+1])
          add_cycle(point_vals[i], point_vals[i+1], point_times[i], point_times[i+1],
                    rcc_pkg::KIND_HALF);
      end
      add_cycle(0, 0, '0, '0, rcc_pkg::KIND_END);
      stack_fill = 0;
    end

    // mark the final result of this request
    if (expected_cycles.size() > queued_before) begin
      tail      = expected_cycles.pop_back();
      tail.last = 1'b1;
      expected_cycles.push_back(tail);
    end
  endtask

  task automatic check_cycle();
    cycle_t want;
    logic   bad;
    if (expected_cycles.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result: tdata=%h kind=%0d last=%0b",
                 m_tdata, m_tuser, m_tlast);
    end else begin
      want = expected_cycles.pop_front();
      bad  = (m_tdata[VW-1:0] != want.dbl_amp)
          || (m_tdata[2*VW:VW] != want.mean2)
          || (m_tdata[2*VW+TW:2*VW+1] != want.t_start)
          || (m_tdata[2*VW+2*TW+1:2*VW+TW+1] != want.period)
          || (m_tdata[2*VW+2*TW+2] != want.ovf)
          || (m_tdata[103:2*VW+2*TW+3] != '0)
          || (m_tuser != want.kind)
          || (m_tlast != want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("cycle mismatch: expected amp=%0d mean=%0d kind=%0d start=%0d",
                   want.dbl_amp, want.mean2, want.kind, want.t_start);
          $display("                expected per=%0d ovf=%0b last=%0b",
                   want.period, want.ovf, want.last);
          $display("                actual   amp=%0d mean=%0d kind=%0d start=%0d",
                   m_tdata[VW-1:0], $signed(m_tdata[2*VW:VW]), m_tuser,
                   m_tdata[2*VW+TW:2*VW+1]);
          $display("                actual   per=%0d ovf=%0b last=%0b pad=%h",
                   m_tdata[2*VW+2*TW+1:2*VW+TW+1], m_tdata[2*VW+2*TW+2], m_tlast,
                   m_tdata[103:2*VW+2*TW+3]);
        end
      end
    end
  endtask

  // results leave before the same-edge request is predicted
  always @(posedge clk) begin
    if (rst) begin
      stack_fill    = 0;
      overflow_seen = 1'b0;
      expected_cycles.delete();
    end else begin
      if (m_tvalid && m_tready) check_cycle();
      if (s_tvalid && s_tready)
        predict_point(s_tdata[VW-1:0], s_tdata[VW+TW-1:VW], s_tlast);
    end
    pending    <= expected_cycles.size();
    fail_count <= mismatches;
  end

endmodule

@@ dv/rainflow_cycle_counter_timed_test.sv @@
// Testbench top for rainflow_cycle_counter_timed: drives turning point runs
// with random idling and a long output stall, and gives the verdict.
// Depends on rcc_pkg, the counter RTL and rainflow_cycle_checker.
module rainflow_cycle_counter_timed_test;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 120;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  int           fail_count;
  int           pending;

  int           s_idle_pct = 0;
  int           r_idle_pct = 0;
  logic         hold_req = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  int           phase_sent;
  logic [31:0]  stamp = '0;

  rainflow_cycle_counter_timed dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  rainflow_cycle_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result side: random backpressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
    end
  end

  // watchdog on cycles with no accepted request on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rainflow_cycle_counter_timed test failed");
      $finish;
    end
  end

  task automatic send_point(logic [15:0] v, logic [31:0] t, logic lst);
    while ($urandom_range(0, 99) < s_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, v};
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    phase_sent++;
  endtask

  // one run of turning points with random content, ended by tlast
  task automatic send_random_run();
    int          len;
    int          mode;
    int          v;
    int          amp;
    logic [31:0] t;
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    mode = $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) stamp = $urandom();
    for (int k = 0; k < len; k++) begin
      case (mode)
        0: v = $signed(16'($urandom()));
        1: v = $urandom_range(0, 40) - 20;
        default: begin
          amp = $urandom_range(0, 32767);
          v   = (k % 2 == 0) ? amp : -amp;
        end
      endcase
      // mostly rising stamps, now and then an arbitrary one
      if ($urandom_range(0, 11) == 0) begin
        t = $urandom();
      end else begin
        stamp = stamp + $urandom_range(0, 2000);
        t     = stamp;
      end
      send_point(16'(v), t, k == len - 1);
    end
  endtask

  // damped oscillation: ranges shrink, nothing pops, stack runs full
  task automatic send_damped_run(int len);
    int top_amp;
    int step;
    int v;
    top_amp = 32767 - $urandom_range(0, 500);
    step    = $urandom_range(50, 400);
    for (int k = 0; k < len; k++) begin
      v     = (k % 2 == 0) ? (top_amp - k * step) : -(top_amp - k * step);
      stamp = stamp + $urandom_range(1, 100);
      send_point(16'(v), stamp, k == len - 1);
    end
  endtask

  // stop offering, then wait until every predicted result has been seen
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of value, wrapping and backward time
    send_point(16'h8000, 32'd0, 1'b0);
    send_point(16'h7fff, 32'd5, 1'b0);
    send_point(16'h8000, 32'hffff_fff0, 1'b0);
    send_point(16'h7fff, 32'hffff_ffff, 1'b0);
    send_point(16'h0000, 32'd3, 1'b1);
    // zero amplitude cycles are skipped
    send_point(16'd10, 32'd100, 1'b0);
    send_point(16'd10, 32'd110, 1'b0);
    send_point(16'd10, 32'd120, 1'b0);
    send_point(16'd20, 32'd130, 1'b1);
    // textbook sequence with half and full cycles
    send_point(-16'sd2, 32'd200, 1'b0);
    send_point(16'sd1, 32'd210, 1'b0);
    send_point(-16'sd3, 32'd220, 1'b0);
    send_point(16'sd5, 32'd230, 1'b0);
    send_point(-16'sd1, 32'd240, 1'b0);
    send_point(16'sd3, 32'd250, 1'b0);
    send_point(-16'sd4, 32'd260, 1'b0);
    send_point(16'sd4, 32'd270, 1'b0);
    send_point(-16'sd2, 32'd280, 1'b1);
    // lone last point gives only the end marker
    send_point(16'd5, 32'd300, 1'b1);
    wait_drained();

    // three idling mixes; the long output hold-off falls in the last
    for (int p = 0; p < 3; p++) begin
      s_idle_pct = (p == 0) ? 38 : (p == 1) ? 67 : 0;
      r_idle_pct <= (p == 0) ? 67 : (p == 1) ? 38 : 0;
      if (p == 2) hold_req <= 1'b1;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) send_random_run();
      wait_drained();
    end

    // full stack: points dropped, sticky flag stays set until reset
    send_damped_run(70);
    for (int k = 0; k < 3; k++) send_random_run();

    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rainflow_cycle_counter_timed test passed");
    end else begin
      $display("rainflow_cycle_counter_timed test failed");
    end
    $finish;
  end

endmodule

@@ rainflow_cycle_counter_timed.f @@
hw/rtl/rcc_pkg.sv
hw/rtl/rcc_ctrl.sv
hw/rtl/rcc_dp.sv
hw/rtl/rainflow_cycle_counter_timed.sv
dv/rainflow_cycle_checker.sv
dv/rainflow_cycle_counter_timed_test.sv
